@@ hw/rtl/sfha_pkg.sv @@
// types, constants and helpers for the segment field accumulator
`timescale 1ns / 1ps
package sfha_pkg;

   // request function codes
   localparam logic [1:0] FN_CLEAR = 2'd0;
   localparam logic [1:0] FN_LOAD  = 2'd1;
   localparam logic [1:0] FN_EVAL  = 2'd2;

   // 1/(4 pi) in Q0.32
   localparam logic signed [35:0] INV4PI_Q32 = 36'sd341782638;

   // running sum clamp and 48-bit output range
   localparam logic signed [64:0] ACC_LIMIT = 65'sh04000000000000000;
   localparam logic signed [63:0] OUT_MAX   = 64'sh00007FFFFFFFFFFF;
   localparam logic signed [63:0] OUT_MIN   = 64'shFFFF800000000000;

   // one stored segment
   typedef struct packed {
      logic signed [31:0] p1x;
      logic signed [31:0] p1y;
      logic signed [31:0] p1z;
      logic signed [31:0] p2x;
      logic signed [31:0] p2y;
      logic signed [31:0] p2z;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] ez;
      logic signed [31:0] cre;
      logic signed [31:0] cim;
      logic               valid;
   } seg_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_LD_INIT,
      S_LD_NORM,
      S_LD_DIRS,
      S_LD_DIRQ,
      S_LD_WRITE,
      S_SSQ_MUL,
      S_SSQ_ACC,
      S_SQRT,
      S_DIV,
      S_EV_INIT,
      S_EV_READ,
      S_EV_PREP,
      S_EV_L1,
      S_EV_L1D,
      S_EV_L2D,
      S_EV_CROSS,
      S_EV_CACC,
      S_EV_CNINIT,
      S_EV_NORM,
      S_EV_DN,
      S_EV_DOT,
      S_EV_DACC,
      S_EV_COSDIV,
      S_EV_COSQ,
      S_EV_QMUL,
      S_EV_Q,
      S_EV_GQ,
      S_EV_UDIV,
      S_EV_UQ,
      S_EV_WMUL,
      S_EV_W,
      S_EV_TMUL,
      S_EV_TACC,
      S_EV_NEXT,
      S_EV_DONE
   } state_type;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic [63:0] mag65(input logic signed [64:0] v);
      return v[64] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] mag66(input logic signed [65:0] v);
      return v[65] ? 64'(-v) : 64'(v);
   endfunction

endpackage

@@ hw/rtl/segment_field_h_accumulator_core.sv @@
// finite straight segment field accumulator: segment table and iterative datapath
`timescale 1ns / 1ps
// Holds up to MAX_SEGMENTS straight current segments and sums their magnetic field
// H at an observation point, in fixed point (Q16.16 in, Q24.24 out, saturating).
// Every request beat carries a function code: clear empties the table at once, load
// stores one segment and works out its unit direction (a zero-length segment is kept
// but never contributes, a load into a full table is dropped), evaluate walks the
// table and returns one result beat. The block handles one request at a time and
// holds req_stall high while it works. All arithmetic goes through one shared
// 36x36 multiplier, one 64-step restoring divider and one 32-step square root
// unit under a single sequencer, so the divider dominates the timing. A finished
// result waits in the output register, so the next request is taken while it is
// still unread. The table needs no clearing pass after reset; only the segment
// count is reset.
module segment_field_h_accumulator_core #(
   parameter int MAX_SEGMENTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic signed [31:0]  req_start_x,
   input  logic signed [31:0]  req_start_y,
   input  logic signed [31:0]  req_start_z,
   input  logic signed [31:0]  req_end_x,
   input  logic signed [31:0]  req_end_y,
   input  logic signed [31:0]  req_end_z,
   input  logic signed [31:0]  req_current_re,
   input  logic signed [31:0]  req_current_im,
   input  logic signed [31:0]  req_obs_x,
   input  logic signed [31:0]  req_obs_y,
   input  logic signed [31:0]  req_obs_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [47:0]  rsp_h_re_x,
   output logic signed [47:0]  rsp_h_re_y,
   output logic signed [47:0]  rsp_h_re_z,
   output logic signed [47:0]  rsp_h_im_x,
   output logic signed [47:0]  rsp_h_im_y,
   output logic signed [47:0]  rsp_h_im_z,
   output logic                rsp_saturated
);
   import sfha_pkg::*;

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   // sequencer
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   // segment table
   seg_type seg_mem [MAX_SEGMENTS];
   seg_type rd_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   // captured request
   logic signed [31:0] st_ff  [3], st_in  [3];
   logic signed [31:0] en_ff  [3], en_in  [3];
   logic signed [31:0] cur_ff [2], cur_in [2];
   logic signed [31:0] obs_ff [3], obs_in [3];

   // load path
   logic [32:0]        na_ff  [3], na_in  [3];
   logic [2:0]         dneg_ff, dneg_in;
   logic signed [31:0] dir_ff [3], dir_in [3];
   logic               ldv_ff, ldv_in;

   // evaluate path
   logic signed [32:0] r1_ff [3], r1_in [3];
   logic signed [32:0] r2_ff [3], r2_in [3];
   logic [1:0]         s_ff, s_in;
   logic [33:0]        m1_ff, m1_in;
   logic [33:0]        m2_ff, m2_in;
   logic signed [64:0] c_ff  [3], c_in  [3];
   logic [63:0]        cm_ff [3], cm_in [3];
   logic [2:0]         cneg_ff, cneg_in;
   logic [5:0]         sh_ff, sh_in;
   logic [31:0]        dn_ff, dn_in;
   logic signed [65:0] dot_ff, dot_in;
   logic signed [33:0] cos1_ff, cos1_in;
   logic signed [33:0] cos2_ff, cos2_in;
   logic signed [33:0] g_ff, g_in;
   logic signed [32:0] u_ff [3], u_in [3];
   logic signed [34:0] w_ff, w_in;
   logic signed [63:0] acc_ff [6], acc_in [6];
   logic [2:0]         k_ff, k_in;
   logic               j_ff, j_in;
   logic               neg_ff, neg_in;

   // sum of squares and square root unit
   logic [30:0] sqv_ff [3], sqv_in [3];
   logic [1:0]  sqk_ff, sqk_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] sx_ff, sx_in;
   logic [63:0] sr_ff, sr_in;
   logic [4:0]  sbi_ff, sbi_in;

   // divider unit
   logic [63:0] div_num_ff, div_num_in;
   logic [33:0] div_rem_ff, div_rem_in;
   logic [33:0] div_den_ff, div_den_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   // shared multiplier
   logic signed [35:0] mul_a, mul_b;
   logic signed [71:0] prod_ff, prod_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] hout_ff [6], hout_in [6];
   logic               sat_ff, sat_in;

   // helpers
   logic signed [32:0] ld_d   [3];
   logic [32:0]        ld_mag [3];
   logic [32:0]        rm1 [3], rm2 [3];
   logic [1:0]         s1, s2;
   logic signed [31:0] ev_e [3];
   logic signed [34:0] dc;
   logic               req_take;

   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      ev_e[0] = rd_ff.ex;
      ev_e[1] = rd_ff.ey;
      ev_e[2] = rd_ff.ez;
      for (int i = 0; i < 3; i++) begin
         ld_d[i]   = 33'(en_ff[i]) - 33'(st_ff[i]);
         ld_mag[i] = mag33(ld_d[i]);
         rm1[i]    = mag33(r1_ff[i]);
         rm2[i]    = mag33(r2_ff[i]);
      end
      // common right shift that brings every magnitude below 2^31
      s1 = (rm1[0][32] | rm1[1][32] | rm1[2][32]) ? 2'd2 :
           (rm1[0][31] | rm1[1][31] | rm1[2][31]) ? 2'd1 : 2'd0;
      s2 = (rm2[0][32] | rm2[1][32] | rm2[2][32]) ? 2'd2 :
           (rm2[0][31] | rm2[1][31] | rm2[2][31]) ? 2'd1 : 2'd0;
      dc = 35'(cos1_ff) - 35'(cos2_ff);
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SSQ_MUL: begin
            mul_a = 36'(signed'({1'b0, sqv_ff[sqk_ff]}));
            mul_b = 36'(signed'({1'b0, sqv_ff[sqk_ff]}));
         end
         S_EV_CROSS: begin
            case (k_ff)
               3'd0: begin mul_a = 36'(ev_e[1]); mul_b = 36'(r1_ff[2]); end
               3'd1: begin mul_a = 36'(ev_e[2]); mul_b = 36'(r1_ff[1]); end
               3'd2: begin mul_a = 36'(ev_e[2]); mul_b = 36'(r1_ff[0]); end
               3'd3: begin mul_a = 36'(ev_e[0]); mul_b = 36'(r1_ff[2]); end
               3'd4: begin mul_a = 36'(ev_e[0]); mul_b = 36'(r1_ff[1]); end
               default: begin mul_a = 36'(ev_e[1]); mul_b = 36'(r1_ff[0]); end
            endcase
         end
         S_EV_DOT: begin
            case (k_ff)
               3'd0: begin mul_a = 36'(r1_ff[0]); mul_b = 36'(ev_e[0]); end
               3'd1: begin mul_a = 36'(r1_ff[1]); mul_b = 36'(ev_e[1]); end
               3'd2: begin mul_a = 36'(r1_ff[2]); mul_b = 36'(ev_e[2]); end
               3'd3: begin mul_a = 36'(r2_ff[0]); mul_b = 36'(ev_e[0]); end
               3'd4: begin mul_a = 36'(r2_ff[1]); mul_b = 36'(ev_e[1]); end
               default: begin mul_a = 36'(r2_ff[2]); mul_b = 36'(ev_e[2]); end
            endcase
         end
         S_EV_QMUL: begin
            mul_a = 36'(dc);
            mul_b = INV4PI_Q32;
         end
         S_EV_WMUL: begin
            mul_a = 36'(g_ff);
            mul_b = j_ff ? 36'(rd_ff.cim) : 36'(rd_ff.cre);
         end
         S_EV_TMUL: begin
            mul_a = 36'(w_ff);
            mul_b = 36'(u_ff[k_ff[1:0]]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FN_LOAD: if (count_ff != CNT_W'(MAX_SEGMENTS)) state_in = S_LD_INIT;
                  FN_EVAL: state_in = S_EV_INIT;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LD_INIT: begin
            if ((ld_mag[0] | ld_mag[1] | ld_mag[2]) == '0) state_in = S_LD_WRITE;
            else state_in = S_LD_NORM;
         end
         S_LD_NORM: begin
            if (((na_ff[0] | na_ff[1] | na_ff[2]) & 33'h1C0000000) == 33'h040000000)
               state_in = S_SSQ_MUL;
         end
         S_LD_DIRS:  state_in = S_DIV;
         S_LD_DIRQ:  state_in = (k_ff == 3'd2) ? S_LD_WRITE : S_LD_DIRS;
         S_LD_WRITE: state_in = S_IDLE;
         S_SSQ_MUL:  state_in = S_SSQ_ACC;
         S_SSQ_ACC:  state_in = (sqk_ff == 2'd2) ? S_SQRT : S_SSQ_MUL;
         S_SQRT:     if (sbi_ff == '0) state_in = ret_ff;
         S_DIV:      if (div_cnt_ff == 6'd63) state_in = ret_ff;
         S_EV_INIT:  state_in = S_EV_READ;
         S_EV_READ:  state_in = (idx_ff == count_ff) ? S_EV_DONE : S_EV_PREP;
         S_EV_PREP:  state_in = rd_ff.valid ? S_EV_L1 : S_EV_NEXT;
         S_EV_L1:    state_in = S_SSQ_MUL;
         S_EV_L1D:   state_in = S_SSQ_MUL;
         S_EV_L2D: begin
            if (m1_ff == '0 || sr_ff[31:0] == '0) state_in = S_EV_NEXT;
            else state_in = S_EV_CROSS;
         end
         S_EV_CROSS:  state_in = S_EV_CACC;
         S_EV_CACC:   state_in = (k_ff == 3'd5) ? S_EV_CNINIT : S_EV_CROSS;
         S_EV_CNINIT: state_in = S_EV_NORM;
         S_EV_NORM: begin
            if ((cm_ff[0] | cm_ff[1] | cm_ff[2]) < 64'h80000000) state_in = S_SSQ_MUL;
         end
         S_EV_DN:     state_in = (sr_ff[31:30] == 2'b00) ? S_EV_NEXT : S_EV_DOT;
         S_EV_DOT:    state_in = S_EV_DACC;
         S_EV_DACC: begin
            if (k_ff == 3'd2 || k_ff == 3'd5) state_in = S_EV_COSDIV;
            else state_in = S_EV_DOT;
         end
         S_EV_COSDIV: state_in = S_DIV;
         S_EV_COSQ:   state_in = (k_ff == 3'd3) ? S_EV_DOT : S_EV_QMUL;
         S_EV_QMUL:   state_in = S_EV_Q;
         S_EV_Q:      state_in = S_DIV;
         S_EV_GQ:     state_in = S_EV_UDIV;
         S_EV_UDIV:   state_in = S_DIV;
         S_EV_UQ:     state_in = (k_ff == 3'd2) ? S_EV_WMUL : S_EV_UDIV;
         S_EV_WMUL:   state_in = S_EV_W;
         S_EV_W:      state_in = S_EV_TMUL;
         S_EV_TMUL:   state_in = S_EV_TACC;
         S_EV_TACC: begin
            if (k_ff != 3'd2) state_in = S_EV_TMUL;
            else if (!j_ff) state_in = S_EV_WMUL;
            else state_in = S_EV_NEXT;
         end
         S_EV_NEXT:   state_in = S_EV_READ;
         S_EV_DONE:   if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      logic [32:0]        or33;
      logic [63:0]        sq_b;
      logic [64:0]        sq_t;
      logic [34:0]        dv_r;
      logic               dv_ge;
      logic signed [71:0] shifted;
      logic signed [33:0] qv;
      logic [32:0]        qmag;
      logic signed [63:0] tprod;
      logic signed [63:0] term;
      logic signed [64:0] s65;
      logic [6:0]         tsh;
      logic [2:0]         ai;
      logic [63:0]        cmor;
      logic signed [63:0] cv;

      ret_in     = ret_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      st_in      = st_ff;
      en_in      = en_ff;
      cur_in     = cur_ff;
      obs_in     = obs_ff;
      na_in      = na_ff;
      dneg_in    = dneg_ff;
      dir_in     = dir_ff;
      ldv_in     = ldv_ff;
      r1_in      = r1_ff;
      r2_in      = r2_ff;
      s_in       = s_ff;
      m1_in      = m1_ff;
      m2_in      = m2_ff;
      c_in       = c_ff;
      cm_in      = cm_ff;
      cneg_in    = cneg_ff;
      sh_in      = sh_ff;
      dn_in      = dn_ff;
      dot_in     = dot_ff;
      cos1_in    = cos1_ff;
      cos2_in    = cos2_ff;
      g_in       = g_ff;
      u_in       = u_ff;
      w_in       = w_ff;
      acc_in     = acc_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      neg_in     = neg_ff;
      sqv_in     = sqv_ff;
      sqk_in     = sqk_ff;
      sum_in     = sum_ff;
      sx_in      = sx_ff;
      sr_in      = sr_ff;
      sbi_in     = sbi_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      hout_in    = hout_ff;
      sat_in     = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      or33    = na_ff[0] | na_ff[1] | na_ff[2];
      sq_b    = 64'(1) << {sbi_ff, 1'b0};
      sq_t    = {1'b0, sr_ff} + {1'b0, sq_b};
      dv_r    = {div_rem_ff, div_num_ff[63]};
      dv_ge   = dv_r >= {1'b0, div_den_ff};
      shifted = prod_ff >>> 28;
      qv      = 34'(shifted);
      qmag    = qv[33] ? 33'(-qv) : 33'(qv);
      tprod   = prod_ff[63:0];
      tsh     = 7'(sh_ff) + 7'd10;
      term    = tprod >>> tsh;
      ai      = j_ff ? (k_ff + 3'd3) : k_ff;
      s65     = 65'(acc_ff[ai]) + 65'(term);
      cmor    = cm_ff[0] | cm_ff[1] | cm_ff[2];
      cv      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               st_in[0]  = req_start_x;
               st_in[1]  = req_start_y;
               st_in[2]  = req_start_z;
               en_in[0]  = req_end_x;
               en_in[1]  = req_end_y;
               en_in[2]  = req_end_z;
               cur_in[0] = req_current_re;
               cur_in[1] = req_current_im;
               obs_in[0] = req_obs_x;
               obs_in[1] = req_obs_y;
               obs_in[2] = req_obs_z;
               if (req_func == FN_CLEAR) count_in = '0;
            end
         end
         S_LD_INIT: begin
            for (int i = 0; i < 3; i++) begin
               na_in[i]   = ld_mag[i];
               dneg_in[i] = ld_d[i][32];
               dir_in[i]  = '0;
            end
            ldv_in = (ld_mag[0] | ld_mag[1] | ld_mag[2]) != '0;
         end
         S_LD_NORM: begin
            // bring the largest magnitude into [2^30, 2^31)
            if (or33[32:31] != 2'b00) begin
               for (int i = 0; i < 3; i++) na_in[i] = na_ff[i] >> 1;
            end else if (!or33[30]) begin
               for (int i = 0; i < 3; i++) na_in[i] = na_ff[i] << 1;
            end else begin
               for (int i = 0; i < 3; i++) sqv_in[i] = na_ff[i][30:0];
               sqk_in = '0;
               sum_in = '0;
               k_in   = '0;
               ret_in = S_LD_DIRS;
            end
         end
         S_LD_DIRS: begin
            // rounded quotient a * 2^30 / L
            div_num_in = (64'(na_ff[k_ff[1:0]]) << 30) + 64'(sr_ff[31:1]);
            div_den_in = 34'(sr_ff[31:0]);
            div_rem_in = '0;
            div_cnt_in = '0;
            neg_in     = dneg_ff[k_ff[1:0]];
            ret_in     = S_LD_DIRQ;
         end
         S_LD_DIRQ: begin
            dir_in[k_ff[1:0]] = neg_ff ? -32'(div_num_ff) : 32'(div_num_ff);
            k_in = k_ff + 3'd1;
         end
         S_LD_WRITE: begin
            count_in = count_ff + CNT_W'(1);
         end
         S_SSQ_ACC: begin
            sum_in = sum_ff + prod_ff[63:0];
            sqk_in = sqk_ff + 2'd1;
            if (sqk_ff == 2'd2) begin
               sx_in  = sum_ff + prod_ff[63:0];
               sr_in  = '0;
               sbi_in = 5'd31;
            end
         end
         S_SQRT: begin
            if ({1'b0, sx_ff} >= sq_t) begin
               sx_in = sx_ff - sq_t[63:0];
               sr_in = (sr_ff >> 1) + sq_b;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sbi_in = sbi_ff - 5'd1;
         end
         S_DIV: begin
            div_rem_in = dv_ge ? 34'(dv_r - {1'b0, div_den_ff}) : dv_r[33:0];
            div_num_in = {div_num_ff[62:0], dv_ge};
            div_cnt_in = div_cnt_ff + 6'd1;
         end
         S_EV_INIT: begin
            idx_in = '0;
            for (int i = 0; i < 6; i++) acc_in[i] = '0;
         end
         S_EV_PREP: begin
            r1_in[0] = 33'(obs_ff[0]) - 33'(rd_ff.p1x);
            r1_in[1] = 33'(obs_ff[1]) - 33'(rd_ff.p1y);
            r1_in[2] = 33'(obs_ff[2]) - 33'(rd_ff.p1z);
            r2_in[0] = 33'(obs_ff[0]) - 33'(rd_ff.p2x);
            r2_in[1] = 33'(obs_ff[1]) - 33'(rd_ff.p2y);
            r2_in[2] = 33'(obs_ff[2]) - 33'(rd_ff.p2z);
         end
         S_EV_L1: begin
            for (int i = 0; i < 3; i++) sqv_in[i] = 31'(rm1[i] >> s1);
            s_in   = s1;
            sqk_in = '0;
            sum_in = '0;
            ret_in = S_EV_L1D;
         end
         S_EV_L1D: begin
            m1_in = 34'(sr_ff[31:0]) << s_ff;
            for (int i = 0; i < 3; i++) sqv_in[i] = 31'(rm2[i] >> s2);
            s_in   = s2;
            sqk_in = '0;
            sum_in = '0;
            ret_in = S_EV_L2D;
         end
         S_EV_L2D: begin
            m2_in = 34'(sr_ff[31:0]) << s_ff;
            for (int i = 0; i < 3; i++) c_in[i] = '0;
            k_in = '0;
         end
         S_EV_CACC: begin
            // cross product e x r1, two products per component
            if (k_ff[0]) c_in[k_ff[2:1]] = c_ff[k_ff[2:1]] - 65'(prod_ff);
            else c_in[k_ff[2:1]] = c_ff[k_ff[2:1]] + 65'(prod_ff);
            k_in = k_ff + 3'd1;
         end
         S_EV_CNINIT: begin
            for (int i = 0; i < 3; i++) begin
               cm_in[i]   = mag65(c_ff[i]);
               cneg_in[i] = c_ff[i][64];
            end
            sh_in = '0;
         end
         S_EV_NORM: begin
            if (cmor >= 64'h80000000) begin
               for (int i = 0; i < 3; i++) cm_in[i] = cm_ff[i] >> 1;
               sh_in = sh_ff + 6'd1;
            end else begin
               for (int i = 0; i < 3; i++) sqv_in[i] = cm_ff[i][30:0];
               sqk_in = '0;
               sum_in = '0;
               ret_in = S_EV_DN;
            end
         end
         S_EV_DN: begin
            dn_in  = sr_ff[31:0];
            dot_in = '0;
            k_in   = '0;
         end
         S_EV_DACC: begin
            dot_in = dot_ff + 66'(prod_ff);
            k_in   = k_ff + 3'd1;
         end
         S_EV_COSDIV: begin
            div_num_in = mag66(dot_ff);
            div_den_in = (k_ff == 3'd3) ? m1_ff : m2_ff;
            div_rem_in = '0;
            div_cnt_in = '0;
            neg_in     = dot_ff[65];
            ret_in     = S_EV_COSQ;
         end
         S_EV_COSQ: begin
            cv = neg_ff ? -64'(div_num_ff[32:0]) : 64'(div_num_ff[32:0]);
            if (k_ff == 3'd3) begin
               cos1_in = 34'(cv);
               dot_in  = '0;
            end else begin
               cos2_in = 34'(cv);
            end
         end
         S_EV_Q: begin
            div_num_in = 64'(qmag) << 30;
            div_den_in = 34'(dn_ff);
            div_rem_in = '0;
            div_cnt_in = '0;
            neg_in     = qv[33];
            ret_in     = S_EV_GQ;
         end
         S_EV_GQ: begin
            g_in = neg_ff ? -34'(div_num_ff[32:0]) : 34'(div_num_ff[32:0]);
            k_in = '0;
         end
         S_EV_UDIV: begin
            div_num_in = 64'(cm_ff[k_ff[1:0]][30:0]) << 30;
            div_den_in = 34'(dn_ff);
            div_rem_in = '0;
            div_cnt_in = '0;
            neg_in     = cneg_ff[k_ff[1:0]];
            ret_in     = S_EV_UQ;
         end
         S_EV_UQ: begin
            u_in[k_ff[1:0]] = neg_ff ? -33'(div_num_ff[31:0]) : 33'(div_num_ff[31:0]);
            k_in = k_ff + 3'd1;
            j_in = 1'b0;
         end
         S_EV_W: begin
            w_in = 35'(prod_ff >>> 30);
            k_in = '0;
         end
         S_EV_TACC: begin
            if (s65 > ACC_LIMIT) acc_in[ai] = 64'(ACC_LIMIT);
            else if (s65 < -ACC_LIMIT) acc_in[ai] = 64'(-ACC_LIMIT);
            else acc_in[ai] = 64'(s65);
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd2) j_in = 1'b1;
         end
         S_EV_NEXT: begin
            idx_in = idx_ff + CNT_W'(1);
         end
         S_EV_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               sat_in = 1'b0;
               for (int i = 0; i < 6; i++) begin
                  if (acc_ff[i] > OUT_MAX) begin
                     hout_in[i] = 48'(OUT_MAX);
                     sat_in = 1'b1;
                  end else if (acc_ff[i] < OUT_MIN) begin
                     hout_in[i] = 48'(OUT_MIN);
                     sat_in = 1'b1;
                  end else begin
                     hout_in[i] = 48'(acc_ff[i]);
                  end
               end
            end
         end
         default: begin
            ret_in = ret_ff;
         end
      endcase
   end

   // segment table: one write port, registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_LD_WRITE) begin
         seg_mem[count_ff[IDX_W-1:0]] <= '{
            p1x: st_ff[0], p1y: st_ff[1], p1z: st_ff[2],
            p2x: en_ff[0], p2y: en_ff[1], p2z: en_ff[2],
            ex: dir_ff[0], ey: dir_ff[1], ez: dir_ff[2],
            cre: cur_ff[0], cim: cur_ff[1], valid: ldv_ff};
      end
      rd_ff <= seg_mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      idx_ff     <= idx_in;
      st_ff      <= st_in;
      en_ff      <= en_in;
      cur_ff     <= cur_in;
      obs_ff     <= obs_in;
      na_ff      <= na_in;
      dneg_ff    <= dneg_in;
      dir_ff     <= dir_in;
      ldv_ff     <= ldv_in;
      r1_ff      <= r1_in;
      r2_ff      <= r2_in;
      s_ff       <= s_in;
      m1_ff      <= m1_in;
      m2_ff      <= m2_in;
      c_ff       <= c_in;
      cm_ff      <= cm_in;
      cneg_ff    <= cneg_in;
      sh_ff      <= sh_in;
      dn_ff      <= dn_in;
      dot_ff     <= dot_in;
      cos1_ff    <= cos1_in;
      cos2_ff    <= cos2_in;
      g_ff       <= g_in;
      u_ff       <= u_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      k_ff       <= k_in;
      j_ff       <= j_in;
      neg_ff     <= neg_in;
      sqv_ff     <= sqv_in;
      sqk_ff     <= sqk_in;
      sum_ff     <= sum_in;
      sx_ff      <= sx_in;
      sr_ff      <= sr_in;
      sbi_ff     <= sbi_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
      prod_ff    <= prod_in;
      hout_ff    <= hout_in;
      sat_ff     <= sat_in;
   end

   // result beat
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_h_re_x    = hout_ff[0];
   assign rsp_h_re_y    = hout_ff[1];
   assign rsp_h_re_z    = hout_ff[2];
   assign rsp_h_im_x    = hout_ff[3];
   assign rsp_h_im_y    = hout_ff[4];
   assign rsp_h_im_z    = hout_ff[5];
   assign rsp_saturated = sat_ff;

endmodule

@@ test/segment_field_h_accumulator_core_tb.sv @@
// testbench for the segment field accumulator: directed, table-full, random and backpressure runs
`timescale 1ns / 1ps
module segment_field_h_accumulator_core_tb;
   import sfha_pkg::*;

   // the fourth function code does nothing
   localparam logic [1:0] FN_NONE = 2'd3;
   localparam int TABLE_DEPTH = 256;
   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint ACC_CLAMP = 64'sd1 << 62;
   localparam longint H_MAX = (64'sd1 <<< 47) - 1;
   localparam longint H_MIN = -(64'sd1 <<< 47);
   localparam longint FOUR_PI_INV = 64'sd341782638;

   // one request beat
   typedef struct {
      logic [1:0]         func;
      logic signed [31:0] pt[6];   // start x/y/z then end x/y/z
      logic signed [31:0] cur_re;
      logic signed [31:0] cur_im;
      logic signed [31:0] obs[3];
   } beat_t;

   // one field result: re x/y/z then im x/y/z
   typedef struct packed {
      logic [5:0][47:0] h;
      logic             sat;
   } field_t;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_func;
   logic signed [31:0] req_start_x, req_start_y, req_start_z;
   logic signed [31:0] req_end_x, req_end_y, req_end_z;
   logic signed [31:0] req_current_re, req_current_im;
   logic signed [31:0] req_obs_x, req_obs_y, req_obs_z;
   logic rsp_valid, rsp_stall;
   logic signed [47:0] rsp_h_re_x, rsp_h_re_y, rsp_h_re_z;
   logic signed [47:0] rsp_h_im_x, rsp_h_im_y, rsp_h_im_z;
   logic rsp_saturated;

   segment_field_h_accumulator_core DUT (.*);

   // shadow copy of the segment table
   logic signed [31:0] tbl_pt[TABLE_DEPTH][6];
   logic signed [31:0] tbl_dir[TABLE_DEPTH][3];
   logic signed [31:0] tbl_cur[TABLE_DEPTH][2];
   bit tbl_ok[TABLE_DEPTH];
   int tbl_count;

   field_t pending_fields[$];
   int errors;
   int send_idle_pct, recv_stall_pct;
   longint cycle_no, recv_hold_until;

   string h_names[6] = '{"h_re_x", "h_re_y", "h_re_z", "h_im_x", "h_im_y", "h_im_z"};

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(64'd12 * 64'd60_000_000);
      $display("FAIL segment_field_h_accumulator_core");
      $finish;
   end

   // ---------------- arithmetic of the field predictor ----------------

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   // bitwise integer square root, floor
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // vector length with a common right shift to keep squares in range
   function automatic longint unsigned vec_length(longint v0, longint v1, longint v2);
      longint unsigned a0 = mag(v0), a1 = mag(v1), a2 = mag(v2);
      int s = 0;
      while (((a0 | a1 | a2) >> s) >= (64'd1 << 31)) s++;
      a0 >>= s; a1 >>= s; a2 >>= s;
      return floor_sqrt(a0 * a0 + a1 * a1 + a2 * a2) << s;
   endfunction

   function automatic longint clamp_add(longint acc, longint t);
      longint s = acc + t;
      if (s > ACC_CLAMP) return ACC_CLAMP;
      if (s < -ACC_CLAMP) return -ACC_CLAMP;
      return s;
   endfunction

   // store a segment and its unit direction, zero length marks it unused
   function automatic void store_segment(beat_t b);
      longint d[3];
      longint unsigned a[3], len;
      longint e;
      int k = tbl_count;
      for (int i = 0; i < 6; i++) tbl_pt[k][i] = b.pt[i];
      tbl_cur[k][0] = b.cur_re;
      tbl_cur[k][1] = b.cur_im;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'(b.pt[3 + i]) - longint'(b.pt[i]);
         a[i] = mag(d[i]);
      end
      tbl_count++;
      if ((a[0] | a[1] | a[2]) == 0) begin
         tbl_ok[k] = 0;
         for (int i = 0; i < 3; i++) tbl_dir[k][i] = '0;
         return;
      end
      while ((a[0] | a[1] | a[2]) >= (64'd1 << 31))
         for (int i = 0; i < 3; i++) a[i] >>= 1;
      while ((a[0] | a[1] | a[2]) < (64'd1 << 30))
         for (int i = 0; i < 3; i++) a[i] <<= 1;
      len = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int i = 0; i < 3; i++) begin
         e = longint'(((a[i] << 30) + (len >> 1)) / len);
         if (d[i] < 0) e = -e;
         tbl_dir[k][i] = e[31:0];
      end
      tbl_ok[k] = 1;
   endfunction

   // sum of the finite-segment field over all usable segments
   function automatic field_t field_at(beat_t b);
      longint acc[6] = '{default: 0};
      longint o[3], r1[3], r2[3], e[3], c[3], cn[3], cur[2];
      longint unsigned m1, m2, a0, a1, a2, dn;
      longint cos1, cos2, q, g, w, u, v;
      int sh;
      field_t f;
      for (int i = 0; i < 3; i++) o[i] = b.obs[i];
      for (int k = 0; k < tbl_count; k++) begin
         if (!tbl_ok[k]) continue;
         for (int i = 0; i < 3; i++) begin
            e[i] = tbl_dir[k][i];
            r1[i] = o[i] - longint'(tbl_pt[k][i]);
            r2[i] = o[i] - longint'(tbl_pt[k][3 + i]);
         end
         m1 = vec_length(r1[0], r1[1], r1[2]);
         m2 = vec_length(r2[0], r2[1], r2[2]);
         // observation point sits on an end point
         if (m1 == 0 || m2 == 0) continue;
         c[0] = e[1] * r1[2] - e[2] * r1[1];
         c[1] = e[2] * r1[0] - e[0] * r1[2];
         c[2] = e[0] * r1[1] - e[1] * r1[0];
         a0 = mag(c[0]); a1 = mag(c[1]); a2 = mag(c[2]);
         sh = 0;
         while (((a0 | a1 | a2) >> sh) >= (64'd1 << 31)) sh++;
         for (int i = 0; i < 3; i++) begin
            v = longint'(mag(c[i]) >> sh);
            cn[i] = c[i] < 0 ? -v : v;
         end
         dn = floor_sqrt(longint'(cn[0] * cn[0]) + longint'(cn[1] * cn[1])
                         + longint'(cn[2] * cn[2]));
         // point on the segment line
         if (dn < (64'd1 << 30)) continue;
         cos1 = (r1[0] * e[0] + r1[1] * e[1] + r1[2] * e[2]) / longint'(m1);
         cos2 = (r2[0] * e[0] + r2[1] * e[1] + r2[2] * e[2]) / longint'(m2);
         q = ((cos1 - cos2) * FOUR_PI_INV) >>> 28;
         g = (q * ONE_Q30) / longint'(dn);
         cur[0] = tbl_cur[k][0];
         cur[1] = tbl_cur[k][1];
         for (int j = 0; j < 2; j++) begin
            w = (g * cur[j]) >>> 30;
            for (int i = 0; i < 3; i++) begin
               u = (cn[i] * ONE_Q30) / longint'(dn);
               acc[3 * j + i] = clamp_add(acc[3 * j + i], (w * u) >>> (10 + sh));
            end
         end
      end
      f.sat = 0;
      for (int i = 0; i < 6; i++) begin
         v = acc[i];
         if (v > H_MAX) begin v = H_MAX; f.sat = 1; end
         if (v < H_MIN) begin v = H_MIN; f.sat = 1; end
         f.h[i] = v[47:0];
      end
      return f;
   endfunction

   // table update and expected field for one accepted beat
   function automatic void track_beat(beat_t b);
      case (b.func)
         FN_CLEAR: tbl_count = 0;
         FN_LOAD:  if (tbl_count < TABLE_DEPTH) store_segment(b);
         FN_EVAL:  pending_fields.push_back(field_at(b));
         default: ;
      endcase
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         1: return $urandom();
         2: case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         default: return 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
      endcase
   endfunction

   function automatic beat_t rand_beat(logic [1:0] func);
      beat_t b;
      int mode = $urandom_range(0, 9);
      mode = mode < 6 ? 0 : mode < 8 ? 1 : mode == 8 ? 2 : 3;
      b.func = func;
      for (int i = 0; i < 6; i++) b.pt[i] = rand_coord(mode);
      b.cur_re = rand_coord($urandom_range(0, 3));
      b.cur_im = rand_coord($urandom_range(0, 3));
      for (int i = 0; i < 3; i++) b.obs[i] = rand_coord(mode);
      return b;
   endfunction

   function automatic beat_t seg_beat(int sx, int sy, int sz, int ex, int ey, int ez,
                                      int cre, int cim);
      beat_t b = rand_beat(FN_LOAD);
      b.pt = '{sx, sy, sz, ex, ey, ez};
      b.cur_re = cre;
      b.cur_im = cim;
      return b;
   endfunction

   function automatic beat_t obs_beat(int x, int y, int z);
      beat_t b = rand_beat(FN_EVAL);
      b.obs = '{x, y, z};
      return b;
   endfunction

   // drive one beat and hold it until the block takes it
   task automatic send_beat(beat_t b);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= b.func;
      req_start_x <= b.pt[0]; req_start_y <= b.pt[1]; req_start_z <= b.pt[2];
      req_end_x <= b.pt[3]; req_end_y <= b.pt[4]; req_end_z <= b.pt[5];
      req_current_re <= b.cur_re;
      req_current_im <= b.cur_im;
      req_obs_x <= b.obs[0]; req_obs_y <= b.obs[1]; req_obs_z <= b.obs[2];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_beat(b);
   endtask

   // wait until every field is back and the block has gone idle
   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_fields.size() != 0 || req_stall) @(posedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      send_beat(rand_beat(FN_CLEAR));
      send_beat(obs_beat(0, 0, 0));                       // empty table
      send_beat(rand_beat(FN_NONE));                      // ignored code
      send_beat(seg_beat(5, 6, 7, 5, 6, 7, 65536, 0));    // zero length
      send_beat(seg_beat(0, 0, -65536, 0, 0, 65536, 65536, -65536));
      send_beat(seg_beat(-65536, 0, 0, 65536, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000));
      send_beat(obs_beat(65536, 65536, 0));
      send_beat(obs_beat(0, 0, 65536));                   // on an end point
      send_beat(obs_beat(0, 0, 3 * 65536));               // on a line
      send_beat(obs_beat(1, 0, 1));                       // just off both lines
      send_beat(obs_beat(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
      send_beat(seg_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                         32'sh7fff_ffff, 32'sh7fff_ffff));
      send_beat(obs_beat(32'sh8000_0000, 32'sh7fff_ffff, 0));
      send_beat(obs_beat(2, 0, 0));
      send_beat(seg_beat(0, 1, 0, 0, 2, 0, 32'sh8000_0000, 32'sh8000_0000));
      send_beat(obs_beat(1, 1, 0));                       // large near field, may clip
      send_beat(rand_beat(FN_CLEAR));
      send_beat(obs_beat(65536, 0, 0));
      wait_drained();
   endtask

   // fill the table past capacity; mostly zero-length so the walk stays short
   task automatic test_table_full();
      send_beat(rand_beat(FN_CLEAR));
      for (int k = 0; k < TABLE_DEPTH; k++)
         if (k == 3 || k == TABLE_DEPTH - 1)
            send_beat(seg_beat(0, 0, k, 65536, 0, k, 65536, 65536));
         else
            send_beat(seg_beat(k, -k, 9, k, -k, 9, 1, 1));
      // dropped: the table is full
      send_beat(seg_beat(0, 65536, 0, 0, 0, 0, 32'sh7fff_ffff, 0));
      send_beat(obs_beat(1000, 70000, -5000));
      send_beat(rand_beat(FN_CLEAR));
      wait_drained();
   endtask

   // loads and evaluations on a small table, with some noise and clears
   task automatic test_random_mix(int beats, int tx_pct, int rx_pct);
      beat_t b;
      int pick, k;
      send_idle_pct = tx_pct;
      recv_stall_pct = rx_pct;
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            b = rand_beat(tbl_count >= 6 && $urandom_range(0, 1) ? FN_CLEAR : FN_LOAD);
            if ($urandom_range(0, 9) == 0) b.pt[3:5] = b.pt[0:2];
         end else if (pick < 90) begin
            b = rand_beat(FN_EVAL);
            if (tbl_count > 0 && $urandom_range(0, 4) == 0) begin
               k = $urandom_range(0, tbl_count - 1);
               for (int i = 0; i < 3; i++)
                  case ($urandom_range(0, 2))
                     0: b.obs[i] = tbl_pt[k][i];
                     1: b.obs[i] = tbl_pt[k][3 + i];
                     default: b.obs[i] = 32'((longint'(tbl_pt[k][i])
                                             + longint'(tbl_pt[k][3 + i])) >>> 1);
                  endcase
            end
         end else if (pick < 95) begin
            b = rand_beat(FN_CLEAR);
         end else begin
            b = rand_beat(FN_NONE);
         end
         send_beat(b);
      end
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // receiver holds off while evaluations keep coming, so the block backs up
   task automatic test_long_hold();
      send_beat(rand_beat(FN_CLEAR));
      send_beat(seg_beat(0, 0, 0, 0, 65536, 0, 65536, 0));
      recv_hold_until = cycle_no + 6000;
      for (int n = 0; n < 8; n++) send_beat(rand_beat(FN_EVAL));
      wait_drained();
   endtask

   // ---------------- receiver and checker ----------------

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset) rsp_stall <= 0;
      else rsp_stall <= (cycle_no < recv_hold_until) || ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      field_t want;
      logic [47:0] got[6];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_h_re_x, rsp_h_re_y, rsp_h_re_z, rsp_h_im_x, rsp_h_im_y, rsp_h_im_z};
         if (pending_fields.size() == 0) begin
            $error("field beat with nothing expected");
            errors++;
         end else begin
            want = pending_fields.pop_front();
            for (int i = 0; i < 6; i++)
               if (got[i] !== want.h[i]) begin
                  $error("%s expected %h actual %h", h_names[i], want.h[i], got[i]);
                  errors++;
               end
            if (rsp_saturated !== want.sat) begin
               $error("saturated expected %b actual %b", want.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      errors = 0;
      cycle_no = 0;
      recv_hold_until = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      tbl_count = 0;
      reset <= 1;
      req_valid <= 0;
      req_func <= FN_CLEAR;
      {req_start_x, req_start_y, req_start_z} <= '0;
      {req_end_x, req_end_y, req_end_z} <= '0;
      {req_current_re, req_current_im} <= '0;
      {req_obs_x, req_obs_y, req_obs_z} <= '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_directed();
      test_table_full();
      test_random_mix(330, 0, 0);
      test_random_mix(330, 72, 0);
      test_random_mix(330, 0, 72);
      test_random_mix(330, 33, 33);
      test_long_hold();
      test_random_mix(200, 0, 0);

      repeat (200) @(posedge clock);
      if (errors == 0 && pending_fields.size() == 0)
         $display("PASS segment_field_h_accumulator_core");
      else
         $display("FAIL segment_field_h_accumulator_core");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/sfha_pkg.sv
hw/rtl/segment_field_h_accumulator_core.sv
test/segment_field_h_accumulator_core_tb.sv
